### src/naa_pkg.sv
`timescale 1ns / 1ps
// package for the network address allocator
// holds field widths, op codes, request and response types; no dependencies

package naa_pkg;

    localparam int ROUTERS_DEF = 16;
    localparam int SLOTS_DEF   = 32;

    localparam int UID_W  = 64;
    localparam int ADDR_W = 16;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              is_tag;
        logic [UID_W-1:0]  unique_id;
        logic [ADDR_W-1:0] parent_addr;
        logic [ADDR_W-1:0] target_addr;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] assigned_addr;
    } t_rsp;

endpackage

### src/naa_req_if.sv
`timescale 1ns / 1ps
// request channel of the network address allocator: valid, ready, payload
// depends on naa_pkg

interface naa_req_if;
    logic          valid;
    logic          ready;
    naa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/naa_rsp_if.sv
`timescale 1ns / 1ps
// response channel of the network address allocator: valid, ready, payload
// depends on naa_pkg

interface naa_rsp_if;
    logic          valid;
    logic          ready;
    naa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/naa_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module naa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/network_address_allocator_unit.sv
`timescale 1ns / 1ps
// network address allocator: one slot table in ram, scanned one entry at a time,
//   each entry read in S_READ and checked in S_CHECK; the response waits in S_RESP
//   until it is accepted, so response stalls hold the unit
// one request at a time, the next taken in the cycle after the response is accepted
// reset: after i_rst_n the table ram is swept clear before the first request is taken

module network_address_allocator_unit #(
    parameter int ROUTERS = naa_pkg::ROUTERS_DEF,
    parameter int SLOTS   = naa_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    naa_req_if.sink    i_req,
    naa_rsp_if.source  o_rsp
);
    import naa_pkg::*;

    localparam int RW    = (ROUTERS > 1) ? $clog2(ROUTERS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = RW + SW;
    localparam int DEPTH = 1 << AW;
    localparam int MW    = UID_W + 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        M_ROUTER = 4'b0001,
        M_FATHER = 4'b0010,
        M_TAG    = 4'b0100,
        M_DELETE = 4'b1000
    } t_mode;

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic              r_is_add, n_is_add;
    logic [UID_W-1:0]  r_uid, n_uid;
    logic [RW-1:0]     r_row, n_row;
    logic [SW-1:0]     r_slot, n_slot;
    logic              r_ok, n_ok;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [AW-1:0]     r_clr, n_clr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [MW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [MW-1:0]     ram_rdata;

    logic              ent_valid;
    logic              id_eq;
    logic              last_row;
    logic              last_slot;
    logic              scan_last;
    logic              scan_hit;
    logic [ADDR_W-1:0] cur_addr;
    logic              father_ok;
    logic              del_ok;
    logic [7:0]        del_low_m1;

    naa_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = {r_row, r_slot};

    assign ent_valid = ram_rdata[UID_W];
    assign id_eq     = (ram_rdata[UID_W-1:0] == r_uid);
    assign last_row  = (r_row == RW'(ROUTERS - 1));
    assign last_slot = (r_slot == SW'(SLOTS - 1));
    assign scan_last = (r_mode == M_ROUTER) ? last_row : last_slot;
    // add wants the first free entry, lookup the first occupied match
    assign scan_hit  = r_is_add ? !ent_valid : (ent_valid && id_eq);
    assign cur_addr  = {8'(r_row), 8'(r_slot) + 8'd1};

    // a father address is row*256+1 with an existing row
    assign father_ok  = (i_req.data.parent_addr[7:0] == 8'd1)
                     && (i_req.data.parent_addr[15:8] < ROUTERS);
    assign del_ok     = (i_req.data.target_addr[15:8] < ROUTERS)
                     && (i_req.data.target_addr[7:0] != 8'd0)
                     && (i_req.data.target_addr[7:0] <= SLOTS);
    assign del_low_m1 = i_req.data.target_addr[7:0] - 8'd1;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_is_add  = r_is_add;
        n_uid     = r_uid;
        n_row     = r_row;
        n_slot    = r_slot;
        n_ok      = r_ok;
        n_addr    = r_addr;
        n_clr     = r_clr;
        ram_we    = 1'b0;
        ram_waddr = {r_row, r_slot};
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_ok     = 1'b0;
                    n_addr   = '0;
                    n_uid    = i_req.data.unique_id;
                    n_is_add = (i_req.data.op == OP_ADD);
                    n_row    = '0;
                    n_slot   = '0;
                    n_state  = S_RESP;
                    case (i_req.data.op)
                        OP_ADD, OP_LOOKUP: begin
                            if (!i_req.data.is_tag) begin
                                n_mode  = M_ROUTER;
                                n_state = S_READ;
                            end else if (father_ok) begin
                                n_mode  = M_FATHER;
                                n_row   = i_req.data.parent_addr[8 +: RW];
                                n_state = S_READ;
                            end
                        end
                        OP_DELETE: begin
                            n_mode = M_DELETE;
                            if (del_ok) begin
                                n_row   = i_req.data.target_addr[8 +: RW];
                                n_slot  = del_low_m1[SW-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_mode = M_DELETE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                case (r_mode)
                    M_ROUTER, M_TAG: begin
                        if (scan_hit) begin
                            if (r_is_add) begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b1, r_uid};
                            end
                            n_ok    = 1'b1;
                            n_addr  = cur_addr;
                            n_state = S_RESP;
                        end else if (scan_last) begin
                            n_state = S_RESP;
                        end else begin
                            if (r_mode == M_ROUTER) begin
                                n_row = r_row + RW'(1);
                            end else begin
                                n_slot = r_slot + SW'(1);
                            end
                            n_state = S_READ;
                        end
                    end
                    M_FATHER: begin
                        // slot 0 of the father row must hold a router
                        if (ent_valid) begin
                            n_mode  = M_TAG;
                            n_state = S_READ;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    M_DELETE: begin
                        if (ent_valid) begin
                            ram_we = 1'b1;
                            n_ok   = 1'b1;
                        end
                        n_state = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= M_DELETE;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_add <= n_is_add;
        r_uid    <= n_uid;
        r_row    <= n_row;
        r_slot   <= n_slot;
        r_ok     <= n_ok;
        r_addr   <= n_addr;
    end

    assign i_req.ready              = (r_state == S_IDLE);
    assign o_rsp.valid              = (r_state == S_RESP);
    assign o_rsp.data.ok            = r_ok;
    assign o_rsp.data.assigned_addr = r_addr;

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.data.ok |-> o_rsp.data.assigned_addr == '0)
        else $error("failed response carries an address");

    a_delete_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_mode == M_DELETE |-> o_rsp.data.assigned_addr == '0)
        else $error("delete response carries an address");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_CHECK))
        else $error("table written outside clear or check");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while a response is pending");

endmodule
